@@ design/pdf_pkg.sv @@
// Shared types and constants of the pixel deglitch filter.
// Used by pdf_regs and by the pixel_deglitch_filter_unit top level.
package pdf_pkg;

    // Default sizing of the line store
    localparam int unsigned MAX_WIDTH_DEF  = 1024;
    localparam int unsigned LINE_COUNT_DEF = 3;

    // Register field widths
    localparam int unsigned CFG_WIDTH_W  = 11;
    localparam int unsigned CFG_HEIGHT_W = 13;
    localparam int unsigned CFG_THRESH_W = 8;

    // Frame height limit
    localparam logic [CFG_HEIGHT_W-1:0] HEIGHT_LIMIT = 13'd4096;

    // Payload widths
    localparam int unsigned PIX_W     = 8;
    localparam int unsigned OUT_ROW_W = 12;
    localparam int unsigned OUT_COL_W = 10;

    // APB port sizing
    localparam int unsigned APB_ADDR_W = 4;
    localparam int unsigned APB_DATA_W = 32;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] REG_THRESHOLD    = 2'd2;

    // Register reset values
    localparam logic [CFG_WIDTH_W-1:0]  RST_IMAGE_WIDTH  = 11'd1024;
    localparam logic [CFG_HEIGHT_W-1:0] RST_IMAGE_HEIGHT = 13'd768;
    localparam logic [CFG_THRESH_W-1:0] RST_THRESHOLD    = 8'd1;

    // Configuration handed from the register block to the datapath
    typedef struct packed {
        logic [CFG_WIDTH_W-1:0]  width;
        logic [CFG_HEIGHT_W-1:0] height;
        logic [CFG_THRESH_W-1:0] thresh;
        logic                    restart;
    } t_cfg;

endpackage

@@ design/pdf_regs.sv @@
// APB configuration registers of the pixel deglitch filter.
// Depends on pdf_pkg for register indexes, widths and reset values.
module pdf_regs (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pdf_pkg::APB_ADDR_W-1:0]    paddr,
    input  logic [pdf_pkg::APB_DATA_W-1:0]    pwdata,
    output logic [pdf_pkg::APB_DATA_W-1:0]    prdata,
    output logic                              pready,
    output pdf_pkg::t_cfg                     o_cfg
);

    logic [pdf_pkg::CFG_WIDTH_W-1:0]  r_width;
    logic [pdf_pkg::CFG_HEIGHT_W-1:0] r_height;
    logic [pdf_pkg::CFG_THRESH_W-1:0] r_thresh;
    logic                             r_restart;
    logic                             wr_en;
    logic [1:0]                       reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[3:2];
    assign wr_en   = psel & penable & pwrite;

    // Write registers; flag a new frame on any geometry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width   <= pdf_pkg::RST_IMAGE_WIDTH;
            r_height  <= pdf_pkg::RST_IMAGE_HEIGHT;
            r_thresh  <= pdf_pkg::RST_THRESHOLD;
            r_restart <= 1'b0;
        end else begin
            r_restart <= 1'b0;
            if (wr_en) begin
                case (reg_idx)
                    pdf_pkg::REG_IMAGE_WIDTH: begin
                        r_width   <= pwdata[pdf_pkg::CFG_WIDTH_W-1:0];
                        r_restart <= 1'b1;
                    end
                    pdf_pkg::REG_IMAGE_HEIGHT: begin
                        r_height  <= pwdata[pdf_pkg::CFG_HEIGHT_W-1:0];
                        r_restart <= 1'b1;
                    end
                    pdf_pkg::REG_THRESHOLD: begin
                        r_thresh <= pwdata[pdf_pkg::CFG_THRESH_W-1:0];
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    // Read back
    always_comb begin
        case (reg_idx)
            pdf_pkg::REG_IMAGE_WIDTH:  prdata = pdf_pkg::APB_DATA_W'(r_width);
            pdf_pkg::REG_IMAGE_HEIGHT: prdata = pdf_pkg::APB_DATA_W'(r_height);
            pdf_pkg::REG_THRESHOLD:    prdata = pdf_pkg::APB_DATA_W'(r_thresh);
            default:                   prdata = '0;
        endcase
    end

    assign o_cfg.width   = r_width;
    assign o_cfg.height  = r_height;
    assign o_cfg.thresh  = r_thresh;
    assign o_cfg.restart = r_restart;

endmodule

@@ design/pixel_deglitch_filter_unit.sv @@
// Top level of the pixel deglitch filter: line store memory and sequencer.
// Depends on pdf_pkg and instantiates pdf_regs.
//
// Usage: pixels enter in raster order on the input channel (i_pix_valid,
// o_pix_ready, i_pixel_in). Each filtered pixel leaves on the output channel
// (o_res_valid, i_res_ready) with its row, column, a replaced flag and a
// frame end flag on the last pixel of the frame. A pixel is emitted once its
// lower neighbor has arrived, so output lags input by about one row; the
// last row is flushed by the input words of that row, up to three results
// for the final word.
// Each result passes through job setup, five reads of the single read port
// of the line store, a read drain and the average; a word that emits nothing
// leaves the sequencer idle for the next word, while a word with results
// holds off the input until they are loaded. The sequential reads of the
// one-port line store limit the rate.
// Reset clears position and control; line store contents are not cleared and
// are never read before being written in the current frame. A stalled
// receiver holds the result in the output register; the next input word is
// taken meanwhile, and its first result waits for the register to drain.
// Writing width or height through APB restarts the frame at row 0, column 0.
module pixel_deglitch_filter_unit #(
    parameter int unsigned MAX_WIDTH  = pdf_pkg::MAX_WIDTH_DEF,
    parameter int unsigned LINE_COUNT = pdf_pkg::LINE_COUNT_DEF
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // pixel input
    input  logic                               i_pix_valid,
    output logic                               o_pix_ready,
    input  logic [pdf_pkg::PIX_W-1:0]          i_pixel_in,
    // result output
    output logic                               o_res_valid,
    input  logic                               i_res_ready,
    output logic [pdf_pkg::PIX_W-1:0]          o_pixel_out,
    output logic [pdf_pkg::OUT_ROW_W-1:0]      o_out_row,
    output logic [pdf_pkg::OUT_COL_W-1:0]      o_out_col,
    output logic                               o_was_replaced,
    output logic                               o_frame_end,
    // APB configuration
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [pdf_pkg::APB_ADDR_W-1:0]     paddr,
    input  logic [pdf_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [pdf_pkg::APB_DATA_W-1:0]     prdata,
    output logic                               pready
);

    localparam int unsigned CW  = $clog2(MAX_WIDTH);
    localparam int unsigned WCW = $clog2(MAX_WIDTH + 1);
    localparam int unsigned EW  = (WCW > pdf_pkg::CFG_WIDTH_W) ? WCW : pdf_pkg::CFG_WIDTH_W;
    localparam int unsigned HW  = pdf_pkg::CFG_HEIGHT_W;
    localparam int unsigned RW  = pdf_pkg::OUT_ROW_W;
    localparam int unsigned LW  = $clog2(LINE_COUNT);
    localparam int unsigned PW  = pdf_pkg::PIX_W;
    localparam int unsigned SW  = PW + 2;   // sum of up to four neighbors
    localparam int unsigned XW  = SW + 1;   // sum plus rounding term

    // Reciprocal of three: (x * 683) >> 11 is exact for x below 1024
    localparam logic [9:0] RECIP3      = 10'd683;
    localparam int unsigned RECIP_SHIFT = 11;
    localparam int unsigned PRODW      = XW + 10;

    // Read slots of one job
    localparam logic [2:0] RD_SELF  = 3'd0;
    localparam logic [2:0] RD_UP    = 3'd1;
    localparam logic [2:0] RD_DOWN  = 3'd2;
    localparam logic [2:0] RD_LEFT  = 3'd3;
    localparam logic [2:0] RD_RIGHT = 3'd4;

    // Job select bits
    localparam int unsigned JOB_ABOVE = 0;  // pixel one row up, same column
    localparam int unsigned JOB_LEFT  = 1;  // last row, previous column
    localparam int unsigned JOB_LAST  = 2;  // last pixel of frame

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_SETUP = 5'b00010,
        S_READ  = 5'b00100,
        S_DRAIN = 5'b01000,
        S_CALC  = 5'b10000
    } t_state;

    pdf_pkg::t_cfg cfg;

    pdf_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    function automatic logic [LW-1:0] line_prev(input logic [LW-1:0] l);
        return (l == '0) ? LW'(LINE_COUNT - 1) : l - LW'(1);
    endfunction

    function automatic logic [LW-1:0] line_next(input logic [LW-1:0] l);
        return (l == LW'(LINE_COUNT - 1)) ? '0 : l + LW'(1);
    endfunction

    t_state          r_state, n_state;

    // Frame position of the next input word
    logic [RW-1:0]   r_row;
    logic [CW-1:0]   r_col;
    logic [LW-1:0]   r_line;

    // Accepted word and its pending jobs
    logic [RW-1:0]   r_item_row;
    logic [CW-1:0]   r_item_col;
    logic [LW-1:0]   r_item_line;
    logic [2:0]      r_jobs;

    // Current job
    logic [2:0]      r_job_sel;
    logic [RW-1:0]   r_job_row;
    logic [CW-1:0]   r_job_col;
    logic [LW-1:0]   r_job_tl, r_job_ul, r_job_dl;
    logic [3:0]      r_exist;   // up, down, left, right in bits 0..3
    logic            r_job_last;

    // Read sequencing and accumulation
    logic [2:0]      r_rd_idx;
    logic            r_dv;
    logic [2:0]      r_dv_idx;
    logic [PW-1:0]   r_rd_data;
    logic [PW-1:0]   r_self;
    logic [SW-1:0]   r_sum;
    logic [2:0]      r_cnt;
    logic            r_far;

    // Line store
    logic [PW-1:0]   r_mem [LINE_COUNT][MAX_WIDTH];

    // Output register
    logic            r_out_valid;
    logic [PW-1:0]   r_out_pixel;
    logic [RW-1:0]   r_out_row;
    logic [CW-1:0]   r_out_col;
    logic            r_out_repl;
    logic            r_out_last;

    // Effective geometry
    logic [EW-1:0]   w_cfg, w_eff;
    logic [HW-1:0]   h_eff;

    always_comb begin
        w_cfg = EW'(cfg.width);
        if (w_cfg == '0) begin
            w_eff = EW'(1);
        end else if (w_cfg > EW'(MAX_WIDTH)) begin
            w_eff = EW'(MAX_WIDTH);
        end else begin
            w_eff = w_cfg;
        end
        if (cfg.height == '0) begin
            h_eff = HW'(1);
        end else if (cfg.height > pdf_pkg::HEIGHT_LIMIT) begin
            h_eff = pdf_pkg::HEIGHT_LIMIT;
        end else begin
            h_eff = cfg.height;
        end
    end

    // Position of the incoming word and the jobs it releases
    logic            pix_acc;
    logic            wrap;
    logic [RW-1:0]   cur_row;
    logic [CW-1:0]   cur_col;
    logic [LW-1:0]   cur_line;
    logic            last_row, last_col;
    logic [2:0]      new_jobs;

    assign o_pix_ready = (r_state == S_IDLE);
    assign pix_acc     = i_pix_valid & o_pix_ready;

    always_comb begin
        wrap     = (HW'(r_row) >= h_eff) || (EW'(r_col) >= w_eff);
        cur_row  = wrap ? '0 : r_row;
        cur_col  = wrap ? '0 : r_col;
        cur_line = wrap ? '0 : r_line;
        last_row = ((HW'(cur_row) + HW'(1)) == h_eff);
        last_col = ((EW'(cur_col) + EW'(1)) == w_eff);
        new_jobs[JOB_ABOVE] = (cur_row != '0);
        new_jobs[JOB_LEFT]  = last_row && (cur_col != '0);
        new_jobs[JOB_LAST]  = last_row && last_col;
    end

    // Pick the lowest pending job and derive its addresses
    logic [2:0]      sel_job;
    logic [RW-1:0]   sel_row;
    logic [CW-1:0]   sel_col;
    logic [LW-1:0]   sel_tl;
    logic [3:0]      sel_exist;

    always_comb begin
        if (r_jobs[JOB_ABOVE]) begin
            sel_job = 3'b001;
        end else if (r_jobs[JOB_LEFT]) begin
            sel_job = 3'b010;
        end else begin
            sel_job = 3'b100;
        end
        sel_row = sel_job[JOB_ABOVE] ? r_item_row - RW'(1) : r_item_row;
        sel_col = sel_job[JOB_LEFT] ? r_item_col - CW'(1) : r_item_col;
        sel_tl  = sel_job[JOB_ABOVE] ? line_prev(r_item_line) : r_item_line;
        sel_exist[0] = (sel_row != '0);
        sel_exist[1] = ((HW'(sel_row) + HW'(1)) < h_eff);
        sel_exist[2] = (sel_col != '0);
        sel_exist[3] = ((EW'(sel_col) + EW'(1)) < w_eff);
    end

    // Read address for the current slot; missing neighbors read self
    logic [LW-1:0]   rd_line;
    logic [CW-1:0]   rd_col;

    always_comb begin
        rd_line = r_job_tl;
        rd_col  = r_job_col;
        case (r_rd_idx)
            RD_UP: begin
                if (r_exist[0]) rd_line = r_job_ul;
            end
            RD_DOWN: begin
                if (r_exist[1]) rd_line = r_job_dl;
            end
            RD_LEFT: begin
                if (r_exist[2]) rd_col = r_job_col - CW'(1);
            end
            RD_RIGHT: begin
                if (r_exist[3]) rd_col = r_job_col + CW'(1);
            end
            default: begin
            end
        endcase
    end

    // Line store: write on accept, registered read while sequencing
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_mem[cur_line][cur_col] <= i_pixel_in;
        end
        if (r_state == S_READ) begin
            r_rd_data <= r_mem[rd_line][rd_col];
        end
    end

    // Neighbor test on returned data
    logic            dv_exist;
    logic [PW-1:0]   nb_diff;

    always_comb begin
        case (r_dv_idx)
            RD_UP:    dv_exist = r_exist[0];
            RD_DOWN:  dv_exist = r_exist[1];
            RD_LEFT:  dv_exist = r_exist[2];
            RD_RIGHT: dv_exist = r_exist[3];
            default:  dv_exist = 1'b0;
        endcase
        nb_diff = (r_rd_data > r_self) ? r_rd_data - r_self : r_self - r_rd_data;
    end

    // Average with half-up rounding, divisor one to four
    logic [XW-1:0]    avg_x;
    logic [PRODW-1:0] avg_prod;
    logic [PW-1:0]    avg_q;
    logic             do_repl;
    logic [PW-1:0]    res_pixel;
    logic             out_free;

    always_comb begin
        avg_x    = XW'(r_sum) + XW'(r_cnt >> 1);
        avg_prod = PRODW'(avg_x) * PRODW'(RECIP3);
        case (r_cnt)
            3'd1:    avg_q = avg_x[PW-1:0];
            3'd2:    avg_q = avg_x[PW:1];
            3'd3:    avg_q = PW'(avg_prod >> RECIP_SHIFT);
            3'd4:    avg_q = avg_x[PW+1:2];
            default: avg_q = r_self;
        endcase
        do_repl   = r_far && (r_cnt != '0);
        res_pixel = do_repl ? avg_q : r_self;
        out_free  = !r_out_valid || i_res_ready;
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (pix_acc && (new_jobs != '0)) n_state = S_SETUP;
            end
            S_SETUP: begin
                n_state = S_READ;
            end
            S_READ: begin
                if (r_rd_idx == RD_RIGHT) n_state = S_DRAIN;
            end
            S_DRAIN: begin
                n_state = S_CALC;
            end
            S_CALC: begin
                if (out_free) begin
                    n_state = ((r_jobs & ~r_job_sel) != '0) ? S_SETUP : S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers: state, position, jobs, read valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_row   <= '0;
            r_col   <= '0;
            r_line  <= '0;
            r_jobs  <= '0;
            r_dv    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_dv    <= (r_state == S_READ);
            if (cfg.restart) begin
                r_row  <= '0;
                r_col  <= '0;
                r_line <= '0;
            end else if (pix_acc) begin
                r_jobs <= new_jobs;
                if (last_col) begin
                    r_col <= '0;
                    if (last_row) begin
                        r_row  <= '0;
                        r_line <= '0;
                    end else begin
                        r_row  <= cur_row + RW'(1);
                        r_line <= line_next(cur_line);
                    end
                end else begin
                    r_row  <= cur_row;
                    r_col  <= cur_col + CW'(1);
                    r_line <= cur_line;
                end
            end
            if ((r_state == S_CALC) && out_free) begin
                r_jobs <= r_jobs & ~r_job_sel;
            end
        end
    end

    // Datapath registers: item, job, read sequence, accumulation
    always_ff @(posedge i_clk) begin
        if (pix_acc) begin
            r_item_row  <= cur_row;
            r_item_col  <= cur_col;
            r_item_line <= cur_line;
        end
        if (r_state == S_SETUP) begin
            r_job_sel  <= sel_job;
            r_job_row  <= sel_row;
            r_job_col  <= sel_col;
            r_job_tl   <= sel_tl;
            r_job_ul   <= line_prev(sel_tl);
            r_job_dl   <= line_next(sel_tl);
            r_exist    <= sel_exist;
            r_job_last <= sel_job[JOB_LAST];
            r_rd_idx   <= RD_SELF;
            r_sum      <= '0;
            r_cnt      <= '0;
            r_far      <= 1'b1;
        end
        if (r_state == S_READ) begin
            r_rd_idx <= r_rd_idx + 3'd1;
        end
        r_dv_idx <= r_rd_idx;
        // accumulate returned neighbor data
        if (r_dv) begin
            if (r_dv_idx == RD_SELF) begin
                r_self <= r_rd_data;
            end else if (dv_exist) begin
                r_sum <= r_sum + SW'(r_rd_data);
                r_cnt <= r_cnt + 3'd1;
                if (nb_diff <= cfg.thresh) r_far <= 1'b0;
            end
        end
    end

    // Output register: load on calc, hold while the receiver stalls
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if ((r_state == S_CALC) && out_free) begin
            r_out_valid <= 1'b1;
        end else if (i_res_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if ((r_state == S_CALC) && out_free) begin
            r_out_pixel <= res_pixel;
            r_out_row   <= r_job_row;
            r_out_col   <= r_job_col;
            r_out_repl  <= do_repl;
            r_out_last  <= r_job_last;
        end
    end

    assign o_res_valid    = r_out_valid;
    assign o_pixel_out    = r_out_pixel;
    assign o_out_row      = r_out_row;
    assign o_out_col      = pdf_pkg::OUT_COL_W'(r_out_col);
    assign o_was_replaced = r_out_repl;
    assign o_frame_end    = r_out_last;

endmodule
